[rtl/chis_pkg.sv]
// chis_pkg: shared types and constants for the chained hash insert/search block
// command and status structs between controller and datapath, status codes,
// register map; used by every file under rtl
package chis_pkg;

    // configuration register widths and reset values
    localparam int unsigned BC_W      = 7;
    localparam int unsigned CAP_W     = 10;
    localparam logic [BC_W-1:0]  BC_RESET  = 7'd64;
    localparam logic [CAP_W-1:0] CAP_RESET = 10'd512;

    // register index, taken from paddr bit 2
    localparam logic REG_BUCKET_COUNT = 1'b0;
    localparam logic REG_CAP_LIMIT    = 1'b1;
    localparam int unsigned PADDR_W   = 3;

    // operation kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // result status codes
    localparam logic [2:0] ST_INSERTED    = 3'd0;
    localparam logic [2:0] ST_OVER_LOAD   = 3'd1;
    localparam logic [2:0] ST_BUCKET_FULL = 3'd2;
    localparam logic [2:0] ST_FOUND       = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic clr;        // clear one fill entry
        logic load;       // capture a new word, start the divide
        logic div_step;   // one restoring divide step
        logic fill_rd;    // read bucket fill, set chain base
        logic insert;     // insert decision and commit
        logic probe_rd;   // read the chain entry at the probe index
        logic not_found;  // set result: not found
        logic found;      // set result: found at probe index
        logic next_idx;   // advance the probe index
        logic load_out;   // move result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic div_last;
        logic is_search;
        logic probe_end;
        logic match;
        logic out_free;
    } t_sts;

endpackage

[rtl/chained_hash_insert_search.sv]
// chained_hash_insert_search: hash table with separate chaining, bucket = key mod count
// top level: APB register block, chis_ctrl state machine, chis_dp datapath;
// depends on chis_pkg
//
//  channel   direction  handshake               payload
//  in        to block   i_in_valid/o_in_ready   i_kind, i_key
//  out       from block o_out_valid/i_out_ready o_status, o_probe_cost
//  config    to block   psel/penable/pwrite     paddr, pwdata (prdata on read)
//
// one word at a time: accept, bit-serial modulo of the key, one fill read,
// then a commit for an insert, or a read and a compare for each chain entry walked on a
// search, and last the load of the output register.
// after reset the fill memory is cleared one bucket a cycle, with o_in_ready low;
// registers can be written meanwhile.
// a new word is not taken until the previous one is done; a stalled output holds.
module chained_hash_insert_search #(
    parameter int MAX_BUCKETS = 64,
    parameter int CHAIN_DEPTH = 8,
    parameter int KEY_BITS    = 31
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input words
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_kind,
    input  logic [KEY_BITS-1:0]                   i_key,
    // results
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [2:0]                            o_status,
    output logic [$clog2(CHAIN_DEPTH+1)-1:0]      o_probe_cost,
    // register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [chis_pkg::PADDR_W-1:0]          paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import chis_pkg::*;

    logic [BC_W-1:0]  r_bucket_count;
    logic [CAP_W-1:0] r_cap_limit;
    logic [BC_W-1:0]  w_divisor;
    logic             w_wr;
    t_cmd             w_cmd;
    t_sts             w_sts;

    // register writes
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BC_RESET;
            r_cap_limit    <= CAP_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_BUCKET_COUNT: r_bucket_count <= pwdata[BC_W-1:0];
                REG_CAP_LIMIT:    r_cap_limit    <= pwdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[2])
            REG_BUCKET_COUNT: prdata = 32'(r_bucket_count);
            REG_CAP_LIMIT:    prdata = 32'(r_cap_limit);
            default:          prdata = '0;
        endcase
    end

    // active bucket count: zero means one, above the table size saturates
    always_comb begin
        if (r_bucket_count == '0) begin
            w_divisor = BC_W'(1);
        end else if (32'(r_bucket_count) > MAX_BUCKETS) begin
            w_divisor = BC_W'(MAX_BUCKETS);
        end else begin
            w_divisor = r_bucket_count;
        end
    end

    chis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    chis_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .CHAIN_DEPTH (CHAIN_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_kind       (i_kind),
        .i_key        (i_key),
        .i_divisor    (w_divisor),
        .i_cap_limit  (r_cap_limit),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_probe_cost (o_probe_cost)
    );

endmodule

[rtl/chis_ctrl.sv]
// chis_ctrl: sequencing state machine for the chained hash block
// drives t_cmd to chis_dp and reads t_sts back; depends on chis_pkg
module chis_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  chis_pkg::t_sts i_sts,
    output chis_pkg::t_cmd o_cmd
);
    import chis_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DIV    = 8'b0000_0100,
        S_FILL   = 8'b0000_1000,
        S_DECIDE = 8'b0001_0000,
        S_PROBE  = 8'b0010_0000,
        S_CMP    = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill_rd = 1'b1;
                n_state = i_sts.is_search ? S_PROBE : S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.insert = 1'b1;
                n_state      = S_RESULT;
            end
            S_PROBE: begin
                if (i_sts.probe_end) begin
                    o_cmd.not_found = 1'b1;
                    n_state         = S_RESULT;
                end else begin
                    o_cmd.probe_rd = 1'b1;
                    n_state        = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.match) begin
                    o_cmd.found = 1'b1;
                    n_state     = S_RESULT;
                end else begin
                    o_cmd.next_idx = 1'b1;
                    n_state        = S_PROBE;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

[rtl/chis_dp.sv]
// chis_dp: datapath of the chained hash block
// serial modulo divider, bucket fill memory, key slot memory, result register;
// commanded by chis_ctrl through chis_pkg::t_cmd
module chis_dp #(
    parameter int MAX_BUCKETS = 64,
    parameter int CHAIN_DEPTH = 8,
    parameter int KEY_BITS    = 31
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  chis_pkg::t_cmd                     i_cmd,
    output chis_pkg::t_sts                     o_sts,
    input  logic                               i_kind,
    input  logic [KEY_BITS-1:0]                i_key,
    input  logic [chis_pkg::BC_W-1:0]          i_divisor,
    input  logic [chis_pkg::CAP_W-1:0]         i_cap_limit,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [2:0]                         o_status,
    output logic [$clog2(CHAIN_DEPTH+1)-1:0]   o_probe_cost
);
    import chis_pkg::*;

    localparam int SLOTS = MAX_BUCKETS * CHAIN_DEPTH;
    localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW    = $clog2(CHAIN_DEPTH + 1);
    localparam int CW    = $clog2(KEY_BITS);

    // memories
    logic [KEY_BITS-1:0] slot_mem [SLOTS];
    logic [FW-1:0]       fill_mem [MAX_BUCKETS];

    // captured word and divider state
    logic                r_kind;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_kshift;
    logic [BC_W-1:0]     r_div;
    logic [BC_W-1:0]     r_rem, n_rem;
    logic [CW-1:0]       r_cnt;
    logic [BC_W:0]       w_rem_sh;
    logic [BW-1:0]       w_bucket;

    // chain walk
    logic [AW-1:0]       r_base;
    logic [FW-1:0]       r_fill_q;
    logic [FW-1:0]       r_idx;
    logic [KEY_BITS-1:0] r_slot_q;

    // clear sweep, attempt counter
    logic [BW-1:0]       r_clr;
    logic [CAP_W-1:0]    r_attempt, n_attempt;

    // result and output registers
    logic [2:0]          r_res_status;
    logic [FW-1:0]       r_res_cost;
    logic                r_out_valid;
    logic [2:0]          r_out_status;
    logic [FW-1:0]       r_out_cost;

    // fill memory write port
    logic                w_fill_we;
    logic [BW-1:0]       w_fill_wa;
    logic [FW-1:0]       w_fill_wd;
    logic                w_over, w_full;

    // one restoring divide step
    always_comb begin
        w_rem_sh = {r_rem, r_kshift[KEY_BITS-1]};
        if (w_rem_sh >= {1'b0, r_div}) begin
            n_rem = BC_W'(w_rem_sh - {1'b0, r_div});
        end else begin
            n_rem = BC_W'(w_rem_sh);
        end
    end

    // remainder is below the divisor, so it fits the bucket index
    assign w_bucket = BW'(r_rem);

    // divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_key    <= i_key;
            r_kshift <= i_key;
            r_div    <= i_divisor;
            r_rem    <= '0;
            r_cnt    <= '0;
        end else if (i_cmd.div_step) begin
            r_kshift <= {r_kshift[KEY_BITS-2:0], 1'b0};
            r_rem    <= n_rem;
            r_cnt    <= r_cnt + 1'b1;
        end
    end

    // insert decision, saturating attempt counter
    always_comb begin
        n_attempt = (r_attempt == '1) ? r_attempt : r_attempt + 1'b1;
        w_over    = n_attempt > i_cap_limit;
        w_full    = r_fill_q >= FW'(CHAIN_DEPTH);
    end

    // fill memory write: clear sweep or append
    always_comb begin
        w_fill_we = i_cmd.clr || (i_cmd.insert && !w_over && !w_full);
        w_fill_wa = i_cmd.clr ? r_clr : w_bucket;
        w_fill_wd = i_cmd.clr ? '0 : r_fill_q + 1'b1;
    end

    // bucket fill memory
    always_ff @(posedge i_clk) begin
        if (w_fill_we) fill_mem[w_fill_wa] <= w_fill_wd;
        if (i_cmd.fill_rd) r_fill_q <= fill_mem[w_bucket];
    end

    // key slot memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && !w_over && !w_full) begin
            slot_mem[r_base + AW'(r_fill_q)] <= r_key;
        end
        if (i_cmd.probe_rd) r_slot_q <= slot_mem[r_base + AW'(r_idx)];
    end

    // chain base and probe index
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_rd) begin
            r_base <= AW'(w_bucket * CHAIN_DEPTH);
            r_idx  <= '0;
        end else if (i_cmd.next_idx) begin
            r_idx  <= r_idx + 1'b1;
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_res_cost <= '0;
            if (w_over) begin
                r_res_status <= ST_OVER_LOAD;
            end else if (w_full) begin
                r_res_status <= ST_BUCKET_FULL;
            end else begin
                r_res_status <= ST_INSERTED;
            end
        end else if (i_cmd.not_found) begin
            r_res_status <= ST_NOT_FOUND;
            r_res_cost   <= '0;
        end else if (i_cmd.found) begin
            r_res_status <= ST_FOUND;
            r_res_cost   <= r_idx + 1'b1;
        end
    end

    // control registers: clear sweep, attempt count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_attempt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.insert) r_attempt <= n_attempt;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_cost   <= r_res_cost;
        end
    end

    // status back to the controller
    always_comb begin
        o_sts.clr_done  = r_clr == BW'(MAX_BUCKETS - 1);
        o_sts.div_last  = r_cnt == CW'(KEY_BITS - 1);
        o_sts.is_search = r_kind == KIND_SEARCH;
        o_sts.probe_end = r_idx >= r_fill_q;
        o_sts.match     = r_slot_q == r_key;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_probe_cost = r_out_cost;

endmodule

[rtl/chis_chk.sv]
// chis_chk: port-level checks for chained_hash_insert_search
// attached by the bind below; depends on chis_pkg
module chis_chk #(
    parameter int CHAIN_DEPTH = 8
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [2:0]                         o_status,
    input logic [$clog2(CHAIN_DEPTH+1)-1:0]   o_probe_cost
);
    import chis_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_probe_cost))
        else $error("stalled result changed");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("word accepted while busy");

    // status is a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_INSERTED || o_status == ST_OVER_LOAD
            || o_status == ST_BUCKET_FULL || o_status == ST_FOUND
            || o_status == ST_NOT_FOUND))
        else $error("undefined status code");

    // a probe cost appears exactly on found, within the chain depth
    a_cost_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status == ST_FOUND) == (o_probe_cost != '0))
            && (32'(o_probe_cost) <= CHAIN_DEPTH))
        else $error("probe cost inconsistent with status");

endmodule

bind chained_hash_insert_search chis_chk #(.CHAIN_DEPTH(CHAIN_DEPTH)) u_chk (.*);
